// ===== rtl/core/julia_pkg.sv =====
package julia_pkg;

  // Fixed-point format and index width.
  localparam int FRAC_BITS  = 24;
  localparam int INDEX_BITS = 12;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int STEP_W  = 25;
  localparam int ITER_W  = 16;
  localparam int RED_W   = 8;
  localparam int IDX_W   = 12;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Multiplier operand and product widths.
  localparam int MUL_IN_W  = 33;
  localparam int MUL_OUT_W = 2 * MUL_IN_W;

  // Divider widths: the dividend is 255 * count.
  localparam int DIVD_W = ITER_W + RED_W;

  // Only the low INDEX_BITS bits of an index are used.
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  // Escape threshold: |z|^2 compared against 16 in the squared scale.
  localparam logic [64:0] ESC_LIMIT = 65'(65'd16 << (2 * FRAC_BITS));

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_C_REAL   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_C_IMAG   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_X_START  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_Y_START  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_X_STEP   = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_Y_STEP   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_MAX_ITER = 3'd6;

  // Reset values of the configuration registers.
  localparam logic signed [COORD_W-1:0] RST_C_REAL  = -32'sd11744051;
  localparam logic signed [COORD_W-1:0] RST_C_IMAG  = 32'sd4362076;
  localparam logic signed [COORD_W-1:0] RST_X_START = -32'sd25165824;
  localparam logic signed [COORD_W-1:0] RST_Y_START = -32'sd16777216;
  localparam logic [STEP_W-1:0]         RST_X_STEP  = 25'd50332;
  localparam logic [STEP_W-1:0]         RST_Y_STEP  = 25'd33554;
  localparam logic [ITER_W-1:0]         RST_MAX_ITER = 16'd1000;

  typedef struct packed {
    logic [IDX_W-1:0] col_index;
    logic [IDX_W-1:0] row_index;
  } pixel_in_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic [RED_W-1:0]  red_level;
  } pixel_out_t;

  // Operand pairs the shared multiplier can form.
  typedef enum logic [2:0] {
    MUL_COL_X,
    MUL_ROW_Y,
    MUL_RE_RE,
    MUL_IM_IM,
    MUL_RE_IM
  } mul_sel_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XMUL,
    ST_YMUL,
    ST_YSET,
    ST_RR,
    ST_II,
    ST_RI,
    ST_UPD,
    ST_FINISH,
    ST_DIV
  } state_t;

  // Divider result returned to the sequencer.
  typedef struct packed {
    logic             valid;
    logic [RED_W-1:0] quotient;
  } div_res_t;

  // Saturate a wide signed value to the signed 32 bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [MUL_OUT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if ((&v[MUL_OUT_W-1:COORD_W-1]) || !(|v[MUL_OUT_W-1:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else if (v[MUL_OUT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/julia_escape_time_pixel_core.sv =====
// Julia set escape-time engine for one pixel at a time.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (c_real, c_imag,
// x_start, y_start, x_step, y_step, max_iter) at the clock edge; write only
// while the core is idle. There is no read-back.
// Input: a pixel transaction is taken at an edge where start is high and busy
// is low; pixel carries the column and row index.
// Output: done is high for exactly one cycle while result holds the iteration
// count and the red level; the receiver must take it in that cycle.
// Steps: the start point takes col*x_step and row*y_step; each iteration then
// takes re*re, im*im and re*im on the shared 33x33 multiplier, then the update,
// until the limit ends the orbit or it escapes. The red level then comes from
// the eight-step restoring divider; with max_iter = 0 the divider is skipped.
// One pixel at a time: busy stays high until the result cycle, and a new
// transaction may be taken in the cycle done is high.
// Reset: rst is synchronous; it returns the sequencer to idle, drops done and
// restores the default registers (c = -0.7 + 0.26i, window from -1.5 - 1.0i,
// max_iter = 1000).
module julia_escape_time_pixel_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  julia_pkg::pixel_in_t              pixel,
  output logic                              done,
  output julia_pkg::pixel_out_t             result,
  input  logic                              cfg_we,
  input  logic [julia_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [julia_pkg::CFG_DW-1:0]      cfg_wdata
);
  import julia_pkg::*;

  // Configuration registers.
  logic signed [COORD_W-1:0] c_real;
  logic signed [COORD_W-1:0] c_imag;
  logic signed [COORD_W-1:0] x_start;
  logic signed [COORD_W-1:0] y_start;
  logic [STEP_W-1:0]         x_step;
  logic [STEP_W-1:0]         y_step;
  logic [ITER_W-1:0]         max_iter;

  // Sequencer and datapath registers.
  state_t                     state;
  state_t                     state_next;
  logic [IDX_W-1:0]           col;
  logic [IDX_W-1:0]           row;
  logic signed [COORD_W-1:0]  re;
  logic signed [COORD_W-1:0]  im;
  logic [63:0]                rr;
  logic signed [63:0]         diff;
  logic [ITER_W-1:0]          count;

  // Shared units.
  mul_sel_t                   mul_sel;
  logic signed [MUL_OUT_W-1:0] prod;
  logic                       div_start;
  logic [DIVD_W-1:0]          div_dividend;
  div_res_t                   div_res;

  // Combinational terms of the escape test and the update.
  logic [64:0]                esc_sum;
  logic                       escaped;
  logic                       at_limit;
  logic signed [MUL_OUT_W-1:0] ri2;
  logic signed [COORD_W-1:0]  re_upd;
  logic signed [COORD_W-1:0]  im_upd;
  logic signed [COORD_W-1:0]  re_init;
  logic signed [COORD_W-1:0]  im_init;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real   <= RST_C_REAL;
      c_imag   <= RST_C_IMAG;
      x_start  <= RST_X_START;
      y_start  <= RST_Y_START;
      x_step   <= RST_X_STEP;
      y_step   <= RST_Y_STEP;
      max_iter <= RST_MAX_ITER;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_C_REAL:   c_real   <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_C_IMAG:   c_imag   <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_X_START:  x_start  <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_Y_START:  y_start  <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_X_STEP:   x_step   <= cfg_wdata[STEP_W-1:0];
        CFG_Y_STEP:   y_step   <= cfg_wdata[STEP_W-1:0];
        CFG_MAX_ITER: max_iter <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  julia_mul u_mul (
    .clk    (clk),
    .sel    (mul_sel),
    .col    (col),
    .row    (row),
    .x_step (x_step),
    .y_step (y_step),
    .re     (re),
    .im     (im),
    .prod   (prod)
  );

  // 255 * count as a shift and a subtract.
  assign div_dividend = ({count, 8'b0}) - DIVD_W'(count);

  julia_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (max_iter),
    .res      (div_res)
  );

  // Escape test on re^2 + im^2, both squares being non-negative.
  assign esc_sum  = {1'b0, rr} + {1'b0, prod[63:0]};
  assign escaped  = (esc_sum >= ESC_LIMIT);
  assign at_limit = (count >= max_iter);

  // Next point: floor shifts are arithmetic right shifts.
  assign ri2     = prod <<< 1;
  assign re_upd  = sat32(MUL_OUT_W'(diff >>> FRAC_BITS) + MUL_OUT_W'(c_real));
  assign im_upd  = sat32((ri2 >>> FRAC_BITS) + MUL_OUT_W'(c_imag));
  assign re_init = sat32(MUL_OUT_W'(x_start) + prod);
  assign im_init = sat32(MUL_OUT_W'(y_start) + prod);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit controls.
  always_comb begin
    state_next = state;
    mul_sel    = MUL_RE_RE;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_XMUL;
        end
      end
      ST_XMUL: begin
        mul_sel    = MUL_COL_X;
        state_next = ST_YMUL;
      end
      ST_YMUL: begin
        mul_sel    = MUL_ROW_Y;
        state_next = ST_YSET;
      end
      ST_YSET: begin
        state_next = ST_RR;
      end
      ST_RR: begin
        mul_sel    = MUL_RE_RE;
        state_next = at_limit ? ST_FINISH : ST_II;
      end
      ST_II: begin
        mul_sel    = MUL_IM_IM;
        state_next = ST_RI;
      end
      ST_RI: begin
        mul_sel    = MUL_RE_IM;
        state_next = escaped ? ST_FINISH : ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_RR;
      end
      ST_FINISH: begin
        if (max_iter == '0) begin
          state_next = ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Datapath registers follow the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          col   <= pixel.col_index & IDX_MASK;
          row   <= pixel.row_index & IDX_MASK;
          count <= '0;
        end
      end
      ST_YMUL: re <= re_init;
      ST_YSET: im <= im_init;
      ST_II:   rr <= prod[63:0];
      ST_RI:   diff <= $signed(rr - prod[63:0]);
      ST_UPD: begin
        re    <= re_upd;
        im    <= im_upd;
        count <= count + 1'b1;
      end
      default: ;
    endcase
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_FINISH) && (max_iter == '0)) ||
              ((state == ST_DIV) && div_res.valid);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && (max_iter == '0)) begin
      result.iterations <= count;
      result.red_level  <= '0;
    end else if ((state == ST_DIV) && div_res.valid) begin
      result.iterations <= count;
      result.red_level  <= div_res.quotient;
    end
  end

endmodule

// ===== rtl/core/julia_mul.sv =====
module julia_mul (
  input  logic                                     clk,
  input  julia_pkg::mul_sel_t                      sel,
  input  logic [julia_pkg::IDX_W-1:0]              col,
  input  logic [julia_pkg::IDX_W-1:0]              row,
  input  logic [julia_pkg::STEP_W-1:0]             x_step,
  input  logic [julia_pkg::STEP_W-1:0]             y_step,
  input  logic signed [julia_pkg::COORD_W-1:0]     re,
  input  logic signed [julia_pkg::COORD_W-1:0]     im,
  output logic signed [julia_pkg::MUL_OUT_W-1:0]   prod
);
  import julia_pkg::*;

  logic signed [MUL_IN_W-1:0] op_a;
  logic signed [MUL_IN_W-1:0] op_b;

  // Choose the operand pair; indexes and steps are unsigned and zero extended.
  always_comb begin
    unique case (sel)
      MUL_COL_X: begin
        op_a = $signed(MUL_IN_W'(col));
        op_b = $signed(MUL_IN_W'(x_step));
      end
      MUL_ROW_Y: begin
        op_a = $signed(MUL_IN_W'(row));
        op_b = $signed(MUL_IN_W'(y_step));
      end
      MUL_RE_RE: begin
        op_a = MUL_IN_W'(re);
        op_b = MUL_IN_W'(re);
      end
      MUL_IM_IM: begin
        op_a = MUL_IN_W'(im);
        op_b = MUL_IN_W'(im);
      end
      MUL_RE_IM: begin
        op_a = MUL_IN_W'(re);
        op_b = MUL_IN_W'(im);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // The product is registered before anything uses it.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ===== rtl/core/julia_div.sv =====
module julia_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [julia_pkg::DIVD_W-1:0]     dividend,
  input  logic [julia_pkg::ITER_W-1:0]     divisor,
  output julia_pkg::div_res_t              res
);
  import julia_pkg::*;

  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] dsh;
  logic [RED_W-1:0]  quo;
  logic [2:0]        step;
  logic              active;
  logic              valid;
  logic              fits;

  // The quotient is known to be below 256, so eight restoring steps suffice.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      valid  <= 1'b0;
    end else begin
      valid <= active && (step == 3'd0);
      if (start) begin
        active <= 1'b1;
      end else if (active && (step == 3'd0)) begin
        active <= 1'b0;
      end
    end
  end

  // One quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= {1'b0, divisor, 7'b0};
      quo  <= '0;
      step <= 3'd7;
    end else if (active) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[RED_W-2:0], fits};
      dsh  <= dsh >> 1;
      step <= step - 3'd1;
    end
  end

  assign res.valid    = valid;
  assign res.quotient = quo;

endmodule

// ===== tb/julia_pixel_checker.sv =====
module julia_pixel_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  julia_pkg::pixel_in_t          pixel,
  input  logic                          done,
  input  julia_pkg::pixel_out_t         result,
  input  logic                          cfg_we,
  input  logic [julia_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [julia_pkg::CFG_DW-1:0]  cfg_wdata,
  output int                            mismatch_count,
  output int                            results_waiting
);
  import julia_pkg::*;

  // The orbit has left the disk of radius 4 once re^2 + im^2 reaches this value.
  localparam logic [63:0] ESCAPE_SQ = 64'd16 << (2 * FRAC_BITS);

  // Shadow copy of the configuration registers.
  logic signed [COORD_W-1:0] julia_re;
  logic signed [COORD_W-1:0] julia_im;
  logic signed [COORD_W-1:0] origin_re;
  logic signed [COORD_W-1:0] origin_im;
  logic [STEP_W-1:0]         step_re;
  logic [STEP_W-1:0]         step_im;
  logic [ITER_W-1:0]         iter_limit;

  // Escape counts predicted for accepted pixels, oldest first.
  pixel_out_t escape_queue[$];

  // Clamp an exact value into the signed 32 bit coordinate range.
  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Iterate z = z*z + c from the pixel's start point and grade the count.
  function automatic pixel_out_t escape_time(input pixel_in_t px);
    longint      re;
    longint      im;
    longint      sq_re;
    longint      sq_im;
    longint      next_re;
    int unsigned count;
    int unsigned red;
    pixel_out_t  res;
    re = clamp32(longint'(origin_re) +
                 longint'(px.col_index & IDX_MASK) * longint'(step_re));
    im = clamp32(longint'(origin_im) +
                 longint'(px.row_index & IDX_MASK) * longint'(step_im));
    count = 0;
    red = 0;
    while (count < iter_limit) begin
      sq_re = re * re;
      sq_im = im * im;
      if ($unsigned(sq_re) + $unsigned(sq_im) >= ESCAPE_SQ) begin
        break;
      end
      // Arithmetic shifts round the products toward minus infinity.
      next_re = clamp32(((sq_re - sq_im) >>> FRAC_BITS) + longint'(julia_re));
      im = clamp32(((2 * re * im) >>> FRAC_BITS) + longint'(julia_im));
      re = next_re;
      count += 1;
    end
    if (iter_limit != 0) begin
      red = (255 * count) / iter_limit;
      if (red > 255) begin
        red = 255;
      end
    end
    res.iterations = ITER_W'(count);
    res.red_level  = RED_W'(red);
    return res;
  endfunction

  // Follow register writes, predict each pixel transaction and check each result.
  always @(posedge clk) begin : monitor
    pixel_out_t want;
    int         errors;
    errors = 0;
    if (rst) begin
      julia_re   <= RST_C_REAL;
      julia_im   <= RST_C_IMAG;
      origin_re  <= RST_X_START;
      origin_im  <= RST_Y_START;
      step_re    <= RST_X_STEP;
      step_im    <= RST_Y_STEP;
      iter_limit <= RST_MAX_ITER;
      escape_queue.delete();
      mismatch_count  <= 0;
      results_waiting <= 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_C_REAL:   julia_re   <= cfg_wdata;
          CFG_C_IMAG:   julia_im   <= cfg_wdata;
          CFG_X_START:  origin_re  <= cfg_wdata;
          CFG_Y_START:  origin_im  <= cfg_wdata;
          CFG_X_STEP:   step_re    <= cfg_wdata[STEP_W-1:0];
          CFG_Y_STEP:   step_im    <= cfg_wdata[STEP_W-1:0];
          CFG_MAX_ITER: iter_limit <= cfg_wdata[ITER_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (escape_queue.size() == 0) begin
          $display("%0t: unexpected result: expected none, got iterations %0d red %0d",
                   $time, result.iterations, result.red_level);
          errors++;
        end else begin
          want = escape_queue.pop_front();
          if (result.iterations !== want.iterations) begin
            $display("%0t: iterations mismatch: expected %0d, got %0d",
                     $time, want.iterations, result.iterations);
            errors++;
          end
          if (result.red_level !== want.red_level) begin
            $display("%0t: red_level mismatch: expected %0d, got %0d",
                     $time, want.red_level, result.red_level);
            errors++;
          end
        end
      end
      // A new transaction may be taken in the same cycle a result leaves.
      if (start && !busy) begin
        escape_queue.push_back(escape_time(pixel));
      end
      mismatch_count  <= mismatch_count + errors;
      results_waiting <= escape_queue.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import julia_pkg::*;

  // Index that selects no register; writes to it must change nothing.
  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;

  localparam int RANDOM_PIXELS  = 584;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int SETTLE_CYCLES  = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  pixel_in_t           pixel = '0;
  logic                done;
  pixel_out_t          result;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  int                  mismatch_count;
  int                  results_waiting;
  int                  quiet_cycles = 0;

  always #1 clk = ~clk;

  julia_escape_time_pixel_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  julia_pixel_checker pixel_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .pixel           (pixel),
    .done            (done),
    .result          (result),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting)
  );

  // End the run if neither a pixel nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves cfg_we high so that a batch of writes runs back to back.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_DW-1:0] c_re, c_im, re0, im0,
                            re_step, im_step, limit);
    write_reg(CFG_C_REAL, c_re);
    write_reg(CFG_C_IMAG, c_im);
    write_reg(CFG_X_START, re0);
    write_reg(CFG_Y_START, im0);
    write_reg(CFG_X_STEP, re_step);
    write_reg(CFG_Y_STEP, im_step);
    write_reg(CFG_MAX_ITER, limit);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel, dropping start at random, until the core takes it.
  task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                            input int idle_pct);
    logic offer;
    pixel <= '{col_index: col, row_index: row};
    do begin
      offer = ($urandom_range(99) >= idle_pct);
      start <= offer;
      @(posedge clk);
    end while (!(offer && !busy));
  endtask

  // Hold off until the core is idle and every predicted result has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  // Either a window over the interesting part of the plane or raw noise.
  task automatic random_window(input bit noisy);
    logic [CFG_DW-1:0] limit_word;
    if (noisy) begin
      limit_word = {16'($urandom), 16'($urandom_range(0, 24))};
      write_reg(CFG_UNUSED, $urandom);
      set_window($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, limit_word);
    end else begin
      limit_word = ($urandom_range(7) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
      set_window($urandom_range(0, 50331648) - 32'd33554432,
                 $urandom_range(0, 33554432) - 32'd16777216,
                 $urandom_range(0, 16777216) - 32'd33554432,
                 $urandom_range(0, 16777216) - 32'd33554432,
                 ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(1024, 16384),
                 ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(1024, 16384),
                 limit_word);
    end
  endtask

  initial begin : stimulus
    int sent;
    int phase;
    int idle_pct;
    int batch;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: corners, alternating bits and a point near the origin.
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd4095, 12'd4095, 0);
    send_pixel(12'd500, 12'd500, 0);
    send_pixel(12'hAAA, 12'h555, 0);
    send_pixel(12'h555, 12'hAAA, 0);
    send_pixel(12'd4095, 12'd0, 0);
    send_pixel(12'd0, 12'd4095, 0);

    // Zero limit: no iterations and no red.
    wait_for_results();
    set_window(RST_C_REAL, RST_C_IMAG, RST_X_START, RST_Y_START,
               32'(RST_X_STEP), 32'(RST_Y_STEP), 32'd0);
    send_pixel(12'd500, 12'd500, 0);
    send_pixel(12'd123, 12'd456, 0);

    // Limit of one: the origin runs out the limit, the point 4.0 escapes at once.
    wait_for_results();
    set_window(32'd0, 32'd0, 32'd0, 32'd0, 32'h0100_0000, 32'h0100_0000, 32'd1);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd4, 12'd0, 0);

    // Saturated start points with the constant at its extremes.
    wait_for_results();
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h01FF_FFFF, 32'h01FF_FFFF, 32'd65535);
    send_pixel(12'd4095, 12'd4095, 0);
    send_pixel(12'd0, 12'd0, 0);

    // Escape test right at and just inside radius 4 on the real axis.
    wait_for_results();
    set_window(32'd0, 32'd0, 32'h03FF_FFFF, 32'd0, 32'd1, 32'd0, 32'd5);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd1, 12'd0, 0);

    // The same on the negative imaginary axis.
    wait_for_results();
    set_window(32'd0, 32'd0, 32'd0, 32'hFC00_0000, 32'd0, 32'd1, 32'd5);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd0, 12'd1, 0);

    // Fixed point at the origin runs the largest limit to the end.
    wait_for_results();
    set_window(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65535);
    send_pixel(12'd0, 12'd0, 0);

    // Random phases, each with its own window and sender idling.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      idle_pct = (phase % 4 == 1) ? 72 : (phase % 4 == 3) ? 23 : 0;
      wait_for_results();
      random_window(phase % 5 == 4);
      batch = $urandom_range(15, 40);
      repeat (batch) begin
        if ($urandom_range(39) == 0) begin
          wait_for_results();
        end
        send_pixel(IDX_W'($urandom), IDX_W'($urandom), idle_pct);
        sent++;
      end
      phase++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
